[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the command line parser.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define TCLP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define TCLP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/tclp_pkg.sv]
// Package of the command line parser: types, character codes, keyword table.
// No dependencies; every RTL module of the parser imports it.
package tclp_pkg;

	localparam int MAX_FIELD_LEN = 256;
	localparam int FCW           = $clog2(MAX_FIELD_LEN + 1);
	localparam int LEN_W         = 9;
	localparam int CMD_MAX       = 6;
	localparam int NUM_KW        = 6;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
	localparam int OUT_FIELDS_W  = 8 + 8 + 3 + 2 * LEN_W + 1;
	localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_UPPER_A  = 8'h41;
	localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	typedef enum logic [2:0] {
		PH_LEAD, PH_CMD, PH_GAP1, PH_KEY, PH_GAP2, PH_VAL, PH_JUNK
	} phase_t;

	typedef enum logic [2:0] {
		CMD_NONE, CMD_QUIT, CMD_SET, CMD_GET, CMD_DEL, CMD_EXISTS
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_KEY, KIND_VALUE, KIND_VERDICT
	} kind_t;

	typedef logic [CMD_MAX-1:0][7:0] cmd_chars_t;

	// One queue entry: an optional key/value byte and an optional verdict.
	typedef struct packed {
		logic              data_vld;
		kind_t             data_kind;
		logic [7:0]        data_byte;
		logic [7:0]        position;
		logic              verdict_vld;
		cmd_t              command_kind;
		logic [LEN_W-1:0]  key_length;
		logic [LEN_W-1:0]  value_length;
		logic              overflow;
	} tclp_item_t;

	typedef struct packed {
		logic empty;
		logic full;
	} tclp_q_status_t;

	// Keywords, first character in byte 0, unused bytes zero.
	localparam cmd_chars_t KW_TEXT [NUM_KW] = '{
		'{8'h00, 8'h00, 8'h74, 8'h69, 8'h75, 8'h71},
		'{8'h00, 8'h00, 8'h74, 8'h69, 8'h78, 8'h65},
		'{8'h00, 8'h00, 8'h00, 8'h74, 8'h65, 8'h73},
		'{8'h00, 8'h00, 8'h00, 8'h74, 8'h65, 8'h67},
		'{8'h00, 8'h00, 8'h00, 8'h6C, 8'h65, 8'h64},
		'{8'h73, 8'h74, 8'h73, 8'h69, 8'h78, 8'h65}
	};
	localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd4, 3'd4, 3'd3, 3'd3, 3'd3, 3'd6};
	localparam cmd_t KW_CODE [NUM_KW] = '{
		CMD_QUIT, CMD_QUIT, CMD_SET, CMD_GET, CMD_DEL, CMD_EXISTS
	};

	function automatic logic is_blank(logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_delim(logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
	endfunction

	// Compare the first n characters against all keywords in parallel.
	function automatic cmd_t kw_match(cmd_chars_t ch, logic [FCW-1:0] n);
		cmd_t r;
		logic same;
		r = CMD_NONE;
		for (int i = 0; i < NUM_KW; i++) begin
			same = (n == FCW'(KW_LEN[i]));
			for (int j = 0; j < CMD_MAX; j++) begin
				if (j < int'(KW_LEN[i]) && ch[j] != KW_TEXT[i][j])
					same = 1'b0;
			end
			if (same)
				r = KW_CODE[i];
		end
		return r;
	endfunction

	// Close the command token: trailing VT/FF only allowed for quit/exit.
	function automatic cmd_t cmd_finish(cmd_chars_t ch, logic [2:0] cnt,
			logic [FCW-1:0] nb, logic too_long);
		cmd_t m;
		m = kw_match(ch, nb);
		if (too_long)
			m = CMD_NONE;
		else if (m != CMD_QUIT && nb != FCW'(cnt))
			m = CMD_NONE;
		return m;
	endfunction

endpackage

[rtl/tclp_front.sv]
// Front end of the command line parser: takes bytes, tracks the line phase,
// matches the command and queues key/value bytes and verdicts. Uses tclp_pkg.
module tclp_front
	import tclp_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [7:0]     s_tdata,    // in_byte[7:0]
	input  logic           s_tlast,    // end_of_line
	input  tclp_q_status_t q_st,
	output logic           push,
	output tclp_item_t     push_item
);

	phase_t           ph_q, ph_st;
	cmd_chars_t       chars_q, chars_st, chars_add;
	logic [2:0]       cnt_q, cnt_st, cnt_add;
	logic             tl_q, tl_st, tl_add;
	cmd_t             match_q, match_st, fin_cur, fin_add;
	logic [FCW-1:0]   fc_q, fc_st, nb_q, nb_st, nb_add;
	logic [FCW-1:0]   keylen_q, keylen_st, fc_inc;
	logic             ovf_q, ovf_st;
	logic             accept, blank, delim, f_full;
	logic [7:0]       lc;
	logic             emit;
	kind_t            emit_kind;
	logic [FCW-1:0]   emit_pos;
	cmd_t             v_cmd;
	logic [FCW-1:0]   v_klen, v_vlen;

	assign s_tready = !q_st.full;
	assign accept   = s_tvalid && s_tready;
	assign blank    = is_blank(s_tdata);
	assign delim    = is_delim(s_tdata);
	assign lc       = (s_tdata >= CH_UPPER_A && s_tdata <= CH_UPPER_Z) ?
		s_tdata + CASE_OFFSET : s_tdata;
	assign f_full   = fc_q >= FCW'(MAX_FIELD_LEN);
	assign fc_inc   = FCW'(fc_q + 1'b1);

	// Command character append
	always_comb begin
		chars_add = chars_q;
		cnt_add   = cnt_q;
		nb_add    = nb_q;
		tl_add    = tl_q;
		if (cnt_q < 3'(CMD_MAX)) begin
			chars_add[cnt_q] = lc;
			cnt_add          = 3'(cnt_q + 1'b1);
			if (!blank)
				nb_add = FCW'(cnt_add);
		end else if (!blank) begin
			tl_add = 1'b1;
		end
	end

	assign fin_cur = cmd_finish(chars_q, cnt_q, nb_q, tl_q);
	assign fin_add = cmd_finish(chars_add, cnt_add, nb_add, tl_add);

	// Next state of the line parser for the accepted byte
	always_comb begin
		ph_st     = ph_q;
		chars_st  = chars_q;
		cnt_st    = cnt_q;
		tl_st     = tl_q;
		match_st  = match_q;
		fc_st     = fc_q;
		nb_st     = nb_q;
		keylen_st = keylen_q;
		ovf_st    = ovf_q;
		emit      = 1'b0;
		emit_kind = KIND_KEY;
		emit_pos  = fc_q;
		unique case (ph_q)
			PH_LEAD: begin
				if (!blank) begin
					chars_st = chars_add;
					cnt_st   = cnt_add;
					nb_st    = nb_add;
					tl_st    = tl_add;
					ph_st    = PH_CMD;
				end
			end
			PH_CMD: begin
				if (delim) begin
					match_st = fin_cur;
					ph_st    = PH_GAP1;
				end else begin
					chars_st = chars_add;
					cnt_st   = cnt_add;
					nb_st    = nb_add;
					tl_st    = tl_add;
				end
			end
			PH_GAP1: begin
				if (!blank) begin
					if (match_q == CMD_NONE || match_q == CMD_QUIT) begin
						ph_st = PH_JUNK;
					end else begin
						fc_st    = FCW'(1);
						nb_st    = FCW'(1);
						emit     = 1'b1;
						emit_pos = '0;
						ph_st    = PH_KEY;
					end
				end
			end
			PH_KEY: begin
				if (delim) begin
					keylen_st = (match_q == CMD_SET) ? fc_q : nb_q;
					ph_st     = PH_GAP2;
				end else if (f_full) begin
					ovf_st = 1'b1;
				end else begin
					emit  = 1'b1;
					fc_st = fc_inc;
					if (!blank)
						nb_st = fc_inc;
				end
			end
			PH_GAP2: begin
				if (!blank) begin
					if (match_q == CMD_SET) begin
						fc_st     = FCW'(1);
						nb_st     = FCW'(1);
						emit      = 1'b1;
						emit_kind = KIND_VALUE;
						emit_pos  = '0;
						ph_st     = PH_VAL;
					end else begin
						ph_st = PH_JUNK;
					end
				end
			end
			PH_VAL: begin
				emit_kind = KIND_VALUE;
				if (f_full) begin
					ovf_st = 1'b1;
				end else begin
					emit  = 1'b1;
					fc_st = fc_inc;
					if (!blank)
						nb_st = fc_inc;
				end
			end
			PH_JUNK: begin
			end
			default: begin
			end
		endcase
	end

	// Outputs: verdict from the state after this byte, and the queue entry
	always_comb begin
		v_cmd  = CMD_NONE;
		v_klen = '0;
		v_vlen = '0;
		unique case (ph_st)
			PH_CMD: begin
				if (fin_add == CMD_QUIT)
					v_cmd = CMD_QUIT;
			end
			PH_GAP1: begin
				if (match_st == CMD_QUIT)
					v_cmd = CMD_QUIT;
			end
			PH_KEY: begin
				if (match_st != CMD_SET) begin
					v_cmd  = match_st;
					v_klen = nb_st;
				end
			end
			PH_GAP2: begin
				if (match_st != CMD_SET) begin
					v_cmd  = match_st;
					v_klen = keylen_st;
				end
			end
			PH_VAL: begin
				v_cmd  = CMD_SET;
				v_klen = keylen_st;
				v_vlen = nb_st;
			end
			default: begin
			end
		endcase
		push                   = accept && (emit || s_tlast);
		push_item.data_vld     = emit;
		push_item.data_kind    = emit_kind;
		push_item.data_byte    = s_tdata;
		push_item.position     = 8'(emit_pos);
		push_item.verdict_vld  = s_tlast;
		push_item.command_kind = v_cmd;
		push_item.key_length   = LEN_W'(v_klen);
		push_item.value_length = LEN_W'(v_vlen);
		push_item.overflow     = ovf_st;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q     <= PH_LEAD;
			chars_q  <= '0;
			cnt_q    <= '0;
			tl_q     <= 1'b0;
			match_q  <= CMD_NONE;
			fc_q     <= '0;
			nb_q     <= '0;
			keylen_q <= '0;
			ovf_q    <= 1'b0;
		end else if (accept) begin
			if (s_tlast) begin
				ph_q     <= PH_LEAD;
				chars_q  <= '0;
				cnt_q    <= '0;
				tl_q     <= 1'b0;
				match_q  <= CMD_NONE;
				fc_q     <= '0;
				nb_q     <= '0;
				keylen_q <= '0;
				ovf_q    <= 1'b0;
			end else begin
				ph_q     <= ph_st;
				chars_q  <= chars_st;
				cnt_q    <= cnt_st;
				tl_q     <= tl_st;
				match_q  <= match_st;
				fc_q     <= fc_st;
				nb_q     <= nb_st;
				keylen_q <= keylen_st;
				ovf_q    <= ovf_st;
			end
		end
	end

endmodule

[rtl/tclp_queue.sv]
// Short queue between the front and back ends of the command line parser.
// Uses tclp_pkg and the assertion macros in assert_macros.svh.
`include "assert_macros.svh"

module tclp_queue
	import tclp_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tclp_item_t     push_item,
	input  logic           pop,
	output tclp_item_t     head_item,
	output tclp_q_status_t q_st
);

	tclp_item_t        entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign head_item = entries_q[rd_ptr_q];
	assign q_st.empty = cnt_q == '0;
	assign q_st.full  = cnt_q == QCNT_W'(QUEUE_DEPTH);

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= QPTR_W'(wr_ptr_q + 1'b1);
			if (pop)
				rd_ptr_q <= QPTR_W'(rd_ptr_q + 1'b1);
			if (push && !pop)
				cnt_q <= QCNT_W'(cnt_q + 1'b1);
			else if (pop && !push)
				cnt_q <= QCNT_W'(cnt_q - 1'b1);
		end
	end

	`TCLP_ASSERT_IMP(a_no_overrun, push, !q_st.full, "push into a full queue")
	`TCLP_ASSERT_IMP(a_no_underrun, pop, !q_st.empty, "pop from an empty queue")
	`TCLP_ASSERT_NXT(a_push_fills, push && !pop, !q_st.empty, "queue empty after a push")

endmodule

[rtl/tclp_back.sv]
// Back end of the command line parser: drains the queue and presents one
// result per transfer from an output register. Uses tclp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tclp_back
	import tclp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  tclp_item_t            head_item,
	input  tclp_q_status_t        q_st,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [1:0]            m_tuser,
	output logic                  m_tlast
);

	logic             valid_q, half_q;
	logic             load, take, data_part;
	kind_t            kind_q;
	logic [7:0]       byte_q, pos_q;
	cmd_t             cmd_q;
	logic [LEN_W-1:0] klen_q, vlen_q;
	logic             ovf_q, last_q;

	assign load      = !valid_q || m_tready;
	assign take      = load && !q_st.empty;
	// A queue entry holding a byte and a verdict goes out in two transfers.
	assign data_part = head_item.data_vld && !half_q;
	assign pop       = take && !(data_part && head_item.verdict_vld);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			half_q  <= 1'b0;
		end else begin
			if (load)
				valid_q <= !q_st.empty;
			if (take)
				half_q <= data_part && head_item.verdict_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (data_part) begin
				kind_q <= head_item.data_kind;
				byte_q <= head_item.data_byte;
				pos_q  <= head_item.position;
				cmd_q  <= CMD_NONE;
				klen_q <= '0;
				vlen_q <= '0;
				ovf_q  <= 1'b0;
				last_q <= 1'b0;
			end else begin
				kind_q <= KIND_VERDICT;
				byte_q <= '0;
				pos_q  <= '0;
				cmd_q  <= head_item.command_kind;
				klen_q <= head_item.key_length;
				vlen_q <= head_item.value_length;
				ovf_q  <= head_item.overflow;
				last_q <= 1'b1;
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}}, ovf_q, vlen_q, klen_q,
		cmd_q, pos_q, byte_q};

	`TCLP_ASSERT_IMP(a_half_pair, half_q, !q_st.empty && head_item.verdict_vld,
		"split entry lost its verdict")
	`TCLP_ASSERT_IMP(a_last_on_verdict, valid_q && last_q, kind_q == KIND_VERDICT,
		"end of run flagged on a data result")

endmodule

[rtl/text_command_line_parser.sv]
// Top level of the text command line parser: front end, queue and back end.
// Depends on tclp_pkg, tclp_front, tclp_queue and tclp_back.
//
//   Channel  Direction  Signals                      Carries
//   s_*      in         tvalid tready tdata tlast    one character of the line per transfer
//   m_*      out        tvalid tready tdata tuser    key byte, value byte or line verdict
//                       tlast
//
// One character is taken in every cycle while the four-entry queue has room.
// A character yields at most one key/value byte, and the last character of a
// line adds the verdict, so that character can give two results; the back end
// sends one result per cycle unless m_tready holds it back. A result passes through
// the queue and then the output register before it is offered on m_tvalid. The front
// end stalls only on a full queue, the back end only on m_tready. The asynchronous
// reset puts the parser before the command of a fresh line and empties the queue
// and the output register.
module text_command_line_parser
	import tclp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // in_byte[7:0]
	input  logic                  s_tlast,   // end_of_line
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// data_byte[7:0], position[15:8], command_kind[18:16], key_length[27:19],
	// value_length[36:28], overflow[37], zero fill[39:38]
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [1:0]            m_tuser,   // result_kind[1:0]
	output logic                  m_tlast    // last
);

	// Front to queue: one entry for every character that produces results.
	logic           push;
	tclp_item_t     push_item;
	// Queue to back end.
	logic           pop;
	tclp_item_t     head_item;
	tclp_q_status_t q_st;

	tclp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.q_st      (q_st),
		.push      (push),
		.push_item (push_item)
	);

	tclp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.q_st      (q_st)
	);

	tclp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_item (head_item),
		.q_st      (q_st),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
